@@ hw/rtl/mctpra_pkg.sv @@
// Shared types and constants for the MCTP-over-SMBus packet reassembler.
package mctpra_pkg;

  localparam int unsigned BufferBytes = 1024;
  localparam int unsigned HeaderBytes = 7;
  localparam int unsigned BufAw       = $clog2(BufferBytes);
  localparam int unsigned LenW        = BufAw + 1;
  localparam int unsigned IdxW        = LenW + 1;
  localparam int unsigned PosW        = 8;
  localparam int unsigned PktLenW     = PosW + 1;
  localparam int unsigned HdrIdxW     = $clog2(HeaderBytes);
  localparam int unsigned QDepth      = 2;
  localparam int unsigned QAw         = $clog2(QDepth);
  localparam int unsigned QCntW       = $clog2(QDepth + 1);

  localparam logic [PosW-1:0] PosMax = '1;

  localparam logic [HdrIdxW-1:0] HdrCount   = 3'd1;
  localparam logic [HdrIdxW-1:0] HdrSrcAddr = 3'd2;
  localparam logic [HdrIdxW-1:0] HdrVersion = 3'd3;
  localparam logic [HdrIdxW-1:0] HdrDstEp   = 3'd4;
  localparam logic [HdrIdxW-1:0] HdrSrcEp   = 3'd5;
  localparam logic [HdrIdxW-1:0] HdrFlags   = 3'd6;

  localparam logic FuncRxByte = 1'b0;
  localparam logic FuncRead   = 1'b1;

  localparam logic ResStatus = 1'b0;
  localparam logic ResRead   = 1'b1;

  localparam logic RegOwnEp  = 1'b0;
  localparam logic RegMinLen = 1'b1;

  typedef enum logic [1:0] {
    OP_READ,
    OP_HEADER,
    OP_PAYLOAD
  } op_kind_e;

  typedef enum logic [2:0] {
    ST_FRAGMENT,
    ST_COMPLETE,
    ST_SHORT,
    ST_COUNT,
    ST_ENDPOINT,
    ST_SEQUENCE,
    ST_OVERFLOW
  } status_e;

  typedef struct packed {
    op_kind_e        kind;
    logic [7:0]      data;
    logic            last;
    logic [PosW-1:0] pos;
    logic [BufAw-1:0] ridx;
  } op_t;

endpackage

@@ hw/rtl/mctpra_front.sv @@
// Front end: tracks the byte position within a packet and classifies each request.
module mctpra_front
  import mctpra_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_func_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  input  logic [BufAw-1:0] in_ridx_i,
  output logic             op_valid_o,
  input  logic             op_ready_i,
  output op_t              op_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            take;

  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i;
  assign take       = in_valid_i && op_ready_i && (in_func_i == FuncRxByte);

  always_comb begin
    op_o.data = in_byte_i;
    op_o.last = in_last_i;
    op_o.pos  = pos_q;
    op_o.ridx = in_ridx_i;
    if (in_func_i == FuncRead) begin
      op_o.kind = OP_READ;
    end else if (pos_q < PosW'(HeaderBytes)) begin
      op_o.kind = OP_HEADER;
    end else begin
      op_o.kind = OP_PAYLOAD;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (take) begin
      if (in_last_i) begin
        pos_d = '0;
      end else if (pos_q != PosMax) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ hw/rtl/mctpra_queue.sv @@
// Two-entry request queue between the front end and the back end.
module mctpra_queue
  import mctpra_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  op_t  in_op_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output op_t  out_op_o
);

  op_t              mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = (count_q != QCntW'(QDepth));
  assign out_valid_o = (count_q != '0);
  assign out_op_o    = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + QAw'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + QAw'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_op_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count exceeds depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + QCntW'(1)))
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - QCntW'(1)))
    else $error("queue count did not shrink on pop");

endmodule

@@ hw/rtl/mctpra_back.sv @@
// Back end: header capture, message buffer, packet checks and the result register.
module mctpra_back
  import mctpra_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      own_ep_i,
  input  logic [7:0]      min_len_i,
  input  logic            op_valid_i,
  output logic            op_ready_o,
  input  op_t             op_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic            res_kind_o,
  output logic [2:0]      res_status_o,
  output logic [LenW-1:0] res_length_o,
  output logic [7:0]      res_src_ep_o,
  output logic [7:0]      res_src_addr_o,
  output logic [7:0]      res_version_o,
  output logic [2:0]      res_tag_o,
  output logic [7:0]      res_rdata_o
);

  logic [7:0]      mem_q [BufferBytes];
  logic [7:0]      low_q [HeaderBytes];
  logic [7:0]      hdr_q [HeaderBytes];
  logic [7:0]      hdr_nx [HeaderBytes];
  logic [LenW-1:0] committed_q, committed_d;
  logic            ctx_q, ctx_d;
  logic [1:0]      prev_seq_q, prev_seq_d;
  logic            ovf_q, ovf_d, ovf_nx;

  logic            out_valid_q;
  logic            out_kind_q;
  logic [2:0]      out_status_q;
  logic [LenW-1:0] out_length_q;
  logic [7:0]      out_src_ep_q, out_src_addr_q, out_version_q;
  logic [2:0]      out_tag_q;
  logic [7:0]      rd_mem_q, rd_low_q;
  logic            rd_sel_low_q;

  logic               advance, go, produces;
  logic               is_byte, is_pay;
  logic               som, eom;
  logic [1:0]         seq;
  logic [PktLenW-1:0] pkt_len;
  logic [IdxW-1:0]    idx;
  logic               in_buf;
  logic               short_pkt, count_bad, ep_bad;
  status_e            status;

  assign advance    = !out_valid_q || res_ready_i;
  assign op_ready_o = advance;
  assign go         = op_valid_i && advance;
  assign is_byte    = (op_i.kind == OP_HEADER) || (op_i.kind == OP_PAYLOAD);
  assign is_pay     = (op_i.kind == OP_PAYLOAD);
  assign produces   = (op_i.kind == OP_READ) || (is_byte && op_i.last);

  always_comb begin
    for (int k = 0; k < HeaderBytes; k++) begin
      hdr_nx[k] = hdr_q[k];
      if (op_i.kind == OP_HEADER) begin
        if (op_i.pos == '0) begin
          hdr_nx[k] = (k == 0) ? op_i.data : 8'h00;
        end else if (op_i.pos == PosW'(k)) begin
          hdr_nx[k] = op_i.data;
        end
      end
    end
  end

  always_comb begin
    som     = hdr_nx[HdrFlags][7];
    eom     = hdr_nx[HdrFlags][6];
    seq     = hdr_nx[HdrFlags][5:4];
    pkt_len = PktLenW'(op_i.pos) + PktLenW'(1);
    if (som) begin
      idx = IdxW'(op_i.pos);
    end else begin
      idx = IdxW'(committed_q) + IdxW'(op_i.pos) - IdxW'(HeaderBytes);
    end
    in_buf    = idx < IdxW'(BufferBytes);
    ovf_nx    = ovf_q || (is_pay && !in_buf);
    short_pkt = (pkt_len < PktLenW'(HeaderBytes)) || (pkt_len < PktLenW'(min_len_i));
    count_bad = (PktLenW'(hdr_nx[HdrCount]) + PktLenW'(2)) != pkt_len;
    ep_bad    = (hdr_nx[HdrDstEp] != own_ep_i) && (hdr_nx[HdrDstEp] != 8'h00);
  end

  always_comb begin
    committed_d = committed_q;
    ctx_d       = ctx_q;
    prev_seq_d  = prev_seq_q;
    ovf_d       = ovf_q;
    status      = ST_FRAGMENT;
    if (go && is_byte) begin
      if (!op_i.last) begin
        ovf_d = ovf_nx || (op_i.pos == PosMax);
      end else begin
        ovf_d = 1'b0;
        if (short_pkt) begin
          status = ST_SHORT;
        end else if (count_bad || ep_bad) begin
          status = count_bad ? ST_COUNT : ST_ENDPOINT;
          if (som) begin
            committed_d = '0;
            ctx_d       = 1'b0;
            prev_seq_d  = '0;
          end
        end else if (som) begin
          if (ovf_nx) begin
            status      = ST_OVERFLOW;
            committed_d = '0;
            ctx_d       = 1'b0;
            prev_seq_d  = '0;
          end else begin
            status      = eom ? ST_COMPLETE : ST_FRAGMENT;
            committed_d = LenW'(pkt_len);
            ctx_d       = !eom;
            prev_seq_d  = eom ? 2'd0 : seq;
          end
        end else if (!ctx_q || (seq != prev_seq_q + 2'd1) || ovf_nx) begin
          status      = (!ctx_q || (seq != prev_seq_q + 2'd1)) ? ST_SEQUENCE : ST_OVERFLOW;
          committed_d = '0;
          ctx_d       = 1'b0;
          prev_seq_d  = '0;
        end else begin
          committed_d = committed_q + LenW'(pkt_len) - LenW'(HeaderBytes);
          status      = eom ? ST_COMPLETE : ST_FRAGMENT;
          ctx_d       = !eom && ctx_q;
          prev_seq_d  = eom ? 2'd0 : seq;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_q <= '0;
      ctx_q       <= 1'b0;
      prev_seq_q  <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < HeaderBytes; k++) begin
        hdr_q[k] <= 8'h00;
      end
    end else begin
      committed_q <= committed_d;
      ctx_q       <= ctx_d;
      prev_seq_q  <= prev_seq_d;
      ovf_q       <= ovf_d;
      if (advance) begin
        out_valid_q <= op_valid_i && produces;
      end
      if (go && (op_i.kind == OP_HEADER)) begin
        for (int k = 0; k < HeaderBytes; k++) begin
          hdr_q[k] <= hdr_nx[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && (op_i.kind == OP_HEADER) && (op_i.pos == PosW'(HdrFlags)) && op_i.data[7]) begin
      for (int k = 0; k < HeaderBytes; k++) begin
        low_q[k] <= hdr_nx[k];
      end
    end else if (go && is_pay && in_buf && (idx < IdxW'(HeaderBytes))) begin
      low_q[HdrIdxW'(idx)] <= op_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && is_pay && in_buf && (idx >= IdxW'(HeaderBytes))) begin
      mem_q[BufAw'(idx)] <= op_i.data;
    end
    if (go && (op_i.kind == OP_READ)) begin
      rd_mem_q <= mem_q[op_i.ridx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_length_q <= committed_d;
      if (op_i.kind == OP_READ) begin
        out_kind_q     <= ResRead;
        out_status_q   <= ST_FRAGMENT;
        out_src_ep_q   <= 8'h00;
        out_src_addr_q <= 8'h00;
        out_version_q  <= 8'h00;
        out_tag_q      <= 3'd0;
        rd_sel_low_q   <= op_i.ridx < BufAw'(HeaderBytes);
        rd_low_q       <= low_q[HdrIdxW'(op_i.ridx)];
      end else begin
        out_kind_q     <= ResStatus;
        out_status_q   <= status;
        out_src_ep_q   <= hdr_nx[HdrSrcEp];
        out_src_addr_q <= hdr_nx[HdrSrcAddr];
        out_version_q  <= hdr_nx[HdrVersion];
        out_tag_q      <= hdr_nx[HdrFlags][2:0];
        rd_sel_low_q   <= 1'b0;
        rd_low_q       <= 8'h00;
      end
    end
  end

  assign res_valid_o    = out_valid_q;
  assign res_kind_o     = out_kind_q;
  assign res_status_o   = out_status_q;
  assign res_length_o   = out_length_q;
  assign res_src_ep_o   = out_src_ep_q;
  assign res_src_addr_o = out_src_addr_q;
  assign res_version_o  = out_version_q;
  assign res_tag_o      = out_tag_q;

  always_comb begin
    if (out_kind_q == ResStatus) begin
      res_rdata_o = 8'h00;
    end else if (rd_sel_low_q) begin
      res_rdata_o = rd_low_q;
    end else begin
      res_rdata_o = rd_mem_q;
    end
  end

  a_ctx_has_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_q |-> (committed_q >= LenW'(HeaderBytes)))
    else $error("open context holds less than one packet");

  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    committed_q <= LenW'(BufferBytes))
    else $error("committed length beyond buffer");

  a_end_clears_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && is_byte && op_i.last) |=> (!ovf_q && out_valid_q && (out_kind_q == ResStatus)))
    else $error("packet end did not clear overflow or post status");

endmodule

@@ hw/rtl/mctp_smbus_packet_reassembler.sv @@
// Top level of the MCTP-over-SMBus packet reassembler.
//
// The slave stream takes one request per cycle. With tuser low a request is
// one received packet byte (tdata[7:0]) with tlast marking the packet's final
// byte; with tuser high it reads the message byte at tdata[17:8]. Every read
// and every final packet byte yields one result on the master stream; other
// packet bytes yield none. An accepted request is first written into the queue, and
// the check and buffer stage, block RAM read included, then registers its result.
// Throughput is one request per cycle as long as results are taken. When the
// receiver stalls, the result register holds and the two-entry queue keeps
// taking requests until it fills, then tready drops.
// Reset empties the queue, closes any message context and sets the length to
// zero; the message buffer itself is not cleared and needs no clearing pass.
// The APB port holds the own endpoint id (address 0) and the minimum packet
// length (address 4); write them only while no request is in flight.
module mctp_smbus_packet_reassembler
  import mctpra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // rx_byte[7:0], read_index[17:8], zero pad
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // packet_status[2:0], message_length[13:3], source_endpoint[21:14],
  // source_address[29:22], header_version[37:30], message_tag[40:38],
  // read_data[48:41], zero pad
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser,  // result_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] own_ep_q, min_len_q;
  logic       cfg_wr;

  logic       f_valid, f_ready;
  op_t        f_op;
  logic       b_valid, b_ready;
  op_t        b_op;

  logic            res_kind;
  logic [2:0]      res_status;
  logic [LenW-1:0] res_length;
  logic [7:0]      res_src_ep, res_src_addr, res_version, res_rdata;
  logic [2:0]      res_tag;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ep_q  <= 8'd0;
      min_len_q <= 8'd8;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegOwnEp:  own_ep_q  <= pwdata[7:0];
        RegMinLen: min_len_q <= pwdata[7:0];
        default:   own_ep_q  <= own_ep_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegOwnEp:  prdata = {24'd0, own_ep_q};
      RegMinLen: prdata = {24'd0, min_len_q};
      default:   prdata = 32'd0;
    endcase
  end

  mctpra_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (s_axis_tuser),
    .in_byte_i  (s_axis_tdata[7:0]),
    .in_last_i  (s_axis_tlast),
    .in_ridx_i  (s_axis_tdata[17:8]),
    .op_valid_o (f_valid),
    .op_ready_i (f_ready),
    .op_o       (f_op)
  );

  mctpra_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_op_i     (f_op),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_op_o    (b_op)
  );

  mctpra_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .own_ep_i       (own_ep_q),
    .min_len_i      (min_len_q),
    .op_valid_i     (b_valid),
    .op_ready_o     (b_ready),
    .op_i           (b_op),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_kind_o     (res_kind),
    .res_status_o   (res_status),
    .res_length_o   (res_length),
    .res_src_ep_o   (res_src_ep),
    .res_src_addr_o (res_src_addr),
    .res_version_o  (res_version),
    .res_tag_o      (res_tag),
    .res_rdata_o    (res_rdata)
  );

  assign m_axis_tuser = res_kind;
  assign m_axis_tdata = {7'd0, res_rdata, res_tag, res_version, res_src_addr,
                         res_src_ep, res_length, res_status};

endmodule

@@ dv/mctp_smbus_reassembly_checker.sv @@
// Checker for the MCTP-over-SMBus packet reassembler: predicts every result and compares it.
`timescale 1ns / 1ps
module mctp_smbus_reassembly_checker
  import mctpra_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [23:0]            s_axis_tdata,
  input  logic                   s_axis_tlast,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [55:0]            m_axis_tdata,
  input  logic                   m_axis_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  input  logic                   pready,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     checked_o,
  output int                     completed_o,
  output logic [BufferBytes-1:0] written_o,
  output logic [LenW-1:0]        held_length_o
);

  localparam int FlagSom    = 7;
  localparam int FlagEom    = 6;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic       kind;
    status_e    status;
    logic [10:0] length;
    logic [7:0] src_ep;
    logic [7:0] src_addr;
    logic [7:0] version;
    logic [2:0] tag;
    logic [7:0] rdata;
  } reassembly_result_t;

  logic [7:0]             msg_mem [BufferBytes];
  logic [BufferBytes-1:0] written_q;
  logic [7:0]             hdr [HeaderBytes];
  int unsigned            held_len;
  int unsigned            byte_pos;
  logic                   ctx_open;
  logic                   pkt_ovf;
  logic [1:0]             prev_seq;
  logic [7:0]             own_ep;
  logic [7:0]             min_len;
  reassembly_result_t     pending_results [$];
  int                     fails;
  int                     checked;
  int                     completed;

  function automatic void drop_context();
    ctx_open = 1'b0;
    held_len = 0;
    prev_seq = 2'd0;
  endfunction

  function automatic status_e judge_packet(input int unsigned plen);
    logic       som;
    logic       eom;
    logic [1:0] seq;
    logic [1:0] next_seq;
    logic [7:0] dest;
    som      = hdr[HdrFlags][FlagSom];
    eom      = hdr[HdrFlags][FlagEom];
    seq      = hdr[HdrFlags][5:4];
    dest     = hdr[HdrDstEp];
    next_seq = prev_seq + 2'd1;
    if (plen < HeaderBytes || plen < min_len) return ST_SHORT;
    if (int'(hdr[HdrCount]) + 2 != plen) begin
      if (som) drop_context();
      return ST_COUNT;
    end
    if (dest != own_ep && dest != 8'd0) begin
      if (som) drop_context();
      return ST_ENDPOINT;
    end
    if (som) begin
      if (pkt_ovf) begin
        drop_context();
        return ST_OVERFLOW;
      end
      held_len = plen;
      ctx_open = !eom;
      prev_seq = eom ? 2'd0 : seq;
      return eom ? ST_COMPLETE : ST_FRAGMENT;
    end
    if (!ctx_open || seq != next_seq) begin
      drop_context();
      return ST_SEQUENCE;
    end
    if (pkt_ovf) begin
      drop_context();
      return ST_OVERFLOW;
    end
    held_len += plen - HeaderBytes;
    if (eom) begin
      ctx_open = 1'b0;
      prev_seq = 2'd0;
      return ST_COMPLETE;
    end
    prev_seq = seq;
    return ST_FRAGMENT;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    int unsigned idx;
    int          k;
    if (byte_pos < HeaderBytes) begin
      if (byte_pos == 0) begin
        for (k = 0; k < HeaderBytes; k++) hdr[k] = 8'd0;
      end
      hdr[byte_pos] = b;
      if (byte_pos == HeaderBytes - 1 && b[FlagSom]) begin
        for (k = 0; k < HeaderBytes; k++) begin
          msg_mem[k]   = hdr[k];
          written_q[k] = 1'b1;
        end
      end
    end else begin
      idx = hdr[HdrFlags][FlagSom] ? byte_pos : held_len + byte_pos - HeaderBytes;
      if (idx < BufferBytes) begin
        msg_mem[idx]   = b;
        written_q[idx] = 1'b1;
      end else begin
        pkt_ovf = 1'b1;
      end
    end
  endfunction

  function automatic void reassemble_request(input logic func, input logic [7:0] b,
                                             input logic last, input logic [9:0] ridx);
    reassembly_result_t r;
    int unsigned        plen;
    r = '0;
    if (func == FuncRead) begin
      r.kind   = ResRead;
      r.status = ST_FRAGMENT;
      r.length = LenW'(held_len);
      r.rdata  = msg_mem[ridx];
      pending_results.push_back(r);
      return;
    end
    absorb_byte(b);
    if (!last) begin
      if (byte_pos >= PosMax) pkt_ovf = 1'b1;
      else byte_pos++;
      return;
    end
    plen       = byte_pos + 1;
    r.kind     = ResStatus;
    r.status   = judge_packet(plen);
    r.length   = LenW'(held_len);
    r.src_ep   = hdr[HdrSrcEp];
    r.src_addr = hdr[HdrSrcAddr];
    r.version  = hdr[HdrVersion];
    r.tag      = hdr[HdrFlags][2:0];
    pending_results.push_back(r);
    byte_pos = 0;
    pkt_ovf  = 1'b0;
  endfunction

  function automatic string describe(input reassembly_result_t r);
    return $sformatf("kind %0d status %0d length %0d src_ep %02h src_addr %02h ver %02h tag %0d data %02h",
                     r.kind, r.status, r.length, r.src_ep, r.src_addr, r.version, r.tag, r.rdata);
  endfunction

  function automatic void check_result(input logic kind, input logic [55:0] d);
    reassembly_result_t got;
    reassembly_result_t want;
    got.kind     = kind;
    got.status   = status_e'(d[2:0]);
    got.length   = d[13:3];
    got.src_ep   = d[21:14];
    got.src_addr = d[29:22];
    got.version  = d[37:30];
    got.tag      = d[40:38];
    got.rdata    = d[48:41];
    checked++;
    if (pending_results.size() == 0) begin
      fails++;
      if (fails <= MaxReports) $display("Result with no request waiting: %s", describe(got));
      return;
    end
    want = pending_results.pop_front();
    if (want.status == ST_COMPLETE && want.kind == ResStatus) completed++;
    if (got.kind !== want.kind || got.status !== want.status || got.length !== want.length ||
        got.src_ep !== want.src_ep || got.src_addr !== want.src_addr ||
        got.version !== want.version || got.tag !== want.tag || got.rdata !== want.rdata) begin
      fails++;
      if (fails <= MaxReports) begin
        $display("Mismatch on result %0d", checked);
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q = '0;
      held_len  = 0;
      byte_pos  = 0;
      ctx_open  = 1'b0;
      pkt_ovf   = 1'b0;
      prev_seq  = 2'd0;
      own_ep    = 8'd0;
      min_len   = 8'd8;
      fails     = 0;
      checked   = 0;
      completed = 0;
      for (int k = 0; k < HeaderBytes; k++) hdr[k] = 8'd0;
      pending_results.delete();
      fail_count_o  <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
      completed_o   <= 0;
      written_o     <= '0;
      held_length_o <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {RegOwnEp, 2'b00}) own_ep = pwdata[7:0];
        else if (paddr == {RegMinLen, 2'b00}) min_len = pwdata[7:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        reassemble_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[17:8]);
      end
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tuser, m_axis_tdata);
      fail_count_o  <= fails;
      pending_o     <= pending_results.size();
      checked_o     <= checked;
      completed_o   <= completed;
      written_o     <= written_q;
      held_length_o <= LenW'(held_len);
    end
  end

endmodule

@@ dv/tb_mctp_smbus_packet_reassembler.sv @@
// Testbench top for the MCTP-over-SMBus packet reassembler: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_mctp_smbus_packet_reassembler;
  import mctpra_pkg::*;

  localparam int DrainCycles = 6;
  localparam int HoldCycles  = 300;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int                     fail_count;
  int                     pending;
  int                     checked;
  int                     completed;
  logic [BufferBytes-1:0] written_map;
  logic [LenW-1:0]        held_length;

  int         items_sent  = 0;
  int         burst_left  = 0;
  bit         no_gap      = 1'b0;
  logic [7:0] cur_ep      = 8'd0;
  int         cur_min     = 8;
  int         rx_cycle    = 0;
  int         accepted    = 0;
  int         hold_left   = 0;
  int         next_hold_at = 250;

  always #5 clk_i = ~clk_i;

  mctp_smbus_packet_reassembler i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  mctp_smbus_reassembly_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .completed_o  (completed),
    .written_o    (written_map),
    .held_length_o(held_length)
  );

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (s_axis_tvalid && s_axis_tready) accepted <= accepted + 1;
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (accepted >= next_hold_at) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HoldCycles;
      next_hold_at  <= next_hold_at + 1150;
    end else begin
      case (rx_cycle[9:8])
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= ($urandom_range(0, 1) == 0);
        2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_cycle[3:0] > 4'd4);
      endcase
    end
  end

  task automatic offer(input logic func, input logic [7:0] b, input logic last,
                       input logic [9:0] ridx);
    int gap;
    if (!no_gap && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {6'b0, ridx, b};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left != 0) burst_left--;
    items_sent++;
  endtask

  task automatic offer_read();
    logic [9:0] idx;
    bit         found;
    int         tries;
    int         hi;
    found = 1'b0;
    for (tries = 0; tries < 6 && !found; tries++) begin
      if (held_length == 0 || $urandom_range(0, 2) == 0) hi = BufferBytes - 1;
      else hi = int'(held_length) - 1;
      idx   = $urandom_range(0, hi);
      found = written_map[idx];
    end
    if (found) offer(FuncRead, $urandom_range(0, 255), $urandom_range(0, 1), idx);
  endtask

  task automatic send_packet(input int n, input logic [7:0] cnt, input logic [7:0] dep,
                             input logic [7:0] flg, input bit with_reads);
    logic [7:0] b;
    int         i;
    for (i = 0; i < n; i++) begin
      if (with_reads && $urandom_range(0, 11) == 0) offer_read();
      case (i)
        HdrCount: b = cnt;
        HdrDstEp: b = dep;
        HdrFlags: b = flg;
        default:  b = $urandom_range(0, 255);
      endcase
      offer(FuncRxByte, b, i == n - 1, $urandom_range(0, 1023));
    end
  endtask

  function automatic int min_accepted();
    return cur_min < HeaderBytes ? HeaderBytes : cur_min;
  endfunction

  function automatic int pick_len();
    int lo;
    lo = min_accepted();
    if (lo > 200 || $urandom_range(0, 31) == 0) return $urandom_range(lo, 256);
    return $urandom_range(lo, lo + 16 > 256 ? 256 : lo + 16);
  endfunction

  function automatic logic [7:0] good_dest();
    return $urandom_range(0, 1) ? cur_ep : 8'd0;
  endfunction

  function automatic logic [7:0] bad_dest();
    logic [7:0] x;
    do x = $urandom_range(0, 255); while (x == cur_ep || x == 8'd0);
    return x;
  endfunction

  task automatic send_message(input int npkt);
    logic [1:0] seq;
    logic [2:0] tag;
    logic [7:0] cnt;
    logic [7:0] dep;
    logic       som;
    logic       owner;
    int         k;
    int         n;
    seq = $urandom_range(0, 3);
    tag = $urandom_range(0, 7);
    for (k = 0; k < npkt; k++) begin
      n     = pick_len();
      cnt   = 8'(n - 2);
      dep   = good_dest();
      som   = (k == 0);
      owner = $urandom_range(0, 1);
      case ($urandom_range(0, 19))
        0: cnt = cnt + 8'($urandom_range(1, 255));
        1: dep = bad_dest();
        2: seq = seq + 2'($urandom_range(1, 3));
        3: n = $urandom_range(1, min_accepted() - 1);
        4: som = ~som;
        default: ;
      endcase
      send_packet(n, cnt, dep, {som, k == npkt - 1, seq, owner, tag}, 1'b1);
      seq = seq + 2'd1;
    end
  endtask

  task automatic run_random(input int budget);
    int first;
    first = items_sent;
    while (items_sent - first < budget) begin
      no_gap = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        8: repeat ($urandom_range(1, 10)) begin
          offer(FuncRxByte, $urandom_range(0, 255), $urandom_range(0, 3) == 0,
                $urandom_range(0, 1023));
        end
        9: repeat ($urandom_range(1, 4)) offer_read();
        default: send_message($urandom_range(1, 4));
      endcase
    end
  endtask

  task automatic send_big_cases();
    logic [1:0] seq;
    seq = $urandom_range(0, 3);
    send_packet(260, 8'd254, good_dest(), {1'b1, 1'b1, seq, 1'b0, 3'd5}, 1'b0);
    offer(FuncRead, 8'hFF, 1'b1, 10'd255);
    offer(FuncRead, 8'h00, 1'b0, 10'd128);
    seq = seq + 2'd1;
    send_packet(8, 8'd6, good_dest(), {1'b0, 1'b1, seq, 1'b1, 3'd2}, 1'b0);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (reg_idx == RegOwnEp) cur_ep = value;
    else cur_min = value;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer(FuncRxByte, 8'hFF, 1'b0, 10'h3FF);
    offer(FuncRxByte, 8'h00, 1'b0, 10'h000);
    offer(FuncRxByte, 8'hFF, 1'b1, 10'h3FF);
    send_packet(8, 8'd6, 8'd0, {1'b1, 1'b0, 2'd3, 1'b1, 3'd7}, 1'b0);
    send_packet(8, 8'd6, 8'd0, {1'b1, 1'b0, 2'd0, 1'b0, 3'd0}, 1'b0);
    send_packet(8, 8'd6, 8'd0, {1'b0, 1'b1, 2'd1, 1'b0, 3'd0}, 1'b0);
    offer(FuncRead, 8'hFF, 1'b1, 10'd0);
    offer(FuncRead, 8'h00, 1'b0, 10'd8);
    send_packet(8, 8'd6, 8'd0, {1'b0, 1'b0, 2'd2, 1'b0, 3'd4}, 1'b0);

    settle();
    apb_write(RegOwnEp, 8'hFF);
    apb_write(RegMinLen, 8'd7);
    run_random(100);
    no_gap = 1'b0;
    send_big_cases();
    run_random(30);

    settle();
    apb_write(RegOwnEp, $urandom_range(1, 254));
    apb_write(RegMinLen, $urandom_range(8, 40));
    run_random(100);

    settle();
    apb_write(RegOwnEp, 8'h00);
    apb_write(RegMinLen, 8'hFF);
    no_gap = 1'b0;
    send_message(1);
    send_packet(20, 8'd18, 8'd0, {1'b1, 1'b1, 2'd0, 1'b0, 3'd1}, 1'b1);
    repeat (4) offer_read();

    settle();
    $display("Sent %0d requests under four register settings, including an overlong packet",
             items_sent);
    $display("and reads of its saturated slot; checked %0d results, %0d complete messages.",
             checked, completed);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timed out with %0d results outstanding", pending);
    $display("Mismatches found");
    $finish;
  end

endmodule
